// ===== rtl/core/v2ndc_pkg.sv =====
package v2ndc_pkg;

    localparam int FRAC_BITS = 16;
    // width of a product after the fraction shift
    localparam int PROD_W    = 64 - FRAC_BITS;
    // sum of four products
    localparam int ACC_W     = PROD_W + 2;
    // magnitude of a projected value shifted up by the fraction bits
    localparam int SCALED_W  = ACC_W + FRAC_BITS;
    // bits above the 32 quotient bits produced by the divider
    localparam int HI_W      = SCALED_W - 32;
    localparam int DIV_STEPS = 32;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD_VIEW = 2'd0;
    localparam cmd_t CMD_LOAD_PROJ = 2'd1;
    localparam cmd_t CMD_XFORM     = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0] lane;
        logic [31:0]     den;
        logic            fault;
        logic [2:0]      num_neg;
        logic [2:0]      neg;
        logic [2:0]      ovf;
    } div_stage_t;

    function automatic logic signed [PROD_W-1:0] fx_mul(input logic signed [31:0] a,
                                                        input logic signed [31:0] b);
        logic signed [63:0] full;
        full = 64'(a) * 64'(b);
        return PROD_W'(full >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(S32_MAX)) begin
            return S32_MAX;
        end else if (v < ACC_W'(S32_MIN)) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/core/vertex_to_ndc_transform.sv =====
// Perspective vertex transform, world space to normalised device coordinates.
// Input channel (s_*): one transaction carries a command. CMD_LOAD_VIEW and
// CMD_LOAD_PROJ write one coefficient (row*4 + column) of the camera-inverse
// or projection matrix and give no result; CMD_XFORM transforms one vertex
// (w = 1) and gives exactly one result transaction; command 3 is dropped.
// Output channel (m_*): ndc_x/y/z in signed Q16.16, saturated, and
// divide_fault when the camera-space z is zero (outputs then saturated by
// the sign of their numerator).
// Throughput: one transaction per cycle while the receiver does not stall. The path
// from acceptance to m_valid runs through five arithmetic stages, a 32-stage
// restoring divider (one quotient bit per stage, three lanes) and the output register.
// Loads may be interleaved with vertices: a projection load takes effect when
// it reaches the stage that reads that matrix, so every vertex sees exactly
// the coefficients loaded before it.
// Reset (aresetn low, synchronous) empties the pipeline; matrix contents are
// undefined until loaded. When the receiver stalls, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated.
module vertex_to_ndc_transform (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  v2ndc_pkg::cmd_t     s_cmd,
    input  logic [3:0]          s_coef_index,
    input  logic signed [31:0]  s_coef_value,
    input  logic signed [31:0]  s_vertex_x,
    input  logic signed [31:0]  s_vertex_y,
    input  logic signed [31:0]  s_vertex_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_ndc_x,
    output logic signed [31:0]  m_ndc_y,
    output logic signed [31:0]  m_ndc_z,
    output logic                m_divide_fault
);
    import v2ndc_pkg::*;

    // global advance: the pipeline moves whenever the output slot is free or taken
    logic adv;
    logic s_acc;

    // matrix stores
    logic signed [31:0] view_reg [16];
    logic signed [31:0] proj_reg [16];

    // stage A: view products
    logic                     a_vld_reg, a_xf_reg;
    logic [3:0]               a_idx_reg;
    logic signed [31:0]       a_coef_reg;
    logic signed [PROD_W-1:0] a_prod_reg [12];
    logic signed [31:0]       a_tr_reg [4];

    // stage B: camera coordinates, index 3 is camera w
    logic                     b_vld_reg, b_xf_reg;
    logic [3:0]               b_idx_reg;
    logic signed [31:0]       b_coef_reg;
    logic signed [31:0]       b_cam_reg [4];

    // stage C: projection products
    logic                     c_vld_reg;
    logic signed [PROD_W-1:0] c_prod_reg [12];
    logic signed [31:0]       c_cz_reg;

    // stage D: projected coordinates
    logic                     d_vld_reg;
    logic signed [ACC_W-1:0]  d_prj_reg [3];
    logic signed [31:0]       d_cz_reg;

    // divider: entry 0 is set up from stage D, entry k+1 after quotient step k
    logic       dv_vld_reg [DIV_STEPS+1];
    div_stage_t dv_reg     [DIV_STEPS+1];
    div_stage_t dv_next    [DIV_STEPS+1];

    // output register
    logic               out_vld_reg;
    logic signed [31:0] ndc_reg [3];
    logic               fault_reg;
    logic signed [31:0] ndc_next [3];

    logic signed [31:0] vtx [3];

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign s_acc   = s_valid && s_ready;
    assign vtx[0]  = s_vertex_x;
    assign vtx[1]  = s_vertex_y;
    assign vtx[2]  = s_vertex_z;

    // matrix writes: view at entry, projection where stage C reads it
    always_ff @(posedge aclk) begin
        if (s_acc && s_cmd == CMD_LOAD_VIEW) begin
            view_reg[s_coef_index] <= s_coef_value;
        end
        if (adv && b_vld_reg && !b_xf_reg) begin
            proj_reg[b_idx_reg] <= b_coef_reg;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            // view loads and unused commands end here
            a_vld_reg <= s_acc && (s_cmd == CMD_XFORM || s_cmd == CMD_LOAD_PROJ);
            b_vld_reg <= a_vld_reg;
            // projection loads end here
            c_vld_reg <= b_vld_reg && b_xf_reg;
            d_vld_reg <= c_vld_reg;
            dv_vld_reg[0] <= d_vld_reg;
            for (int k = 0; k < DIV_STEPS; k++) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    // stages A to D
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_xf_reg   <= (s_cmd == CMD_XFORM);
            a_idx_reg  <= s_coef_index;
            a_coef_reg <= s_coef_value;
            for (int i = 0; i < 4; i++) begin
                a_tr_reg[i] <= view_reg[i*4+3];
                for (int j = 0; j < 3; j++) begin
                    a_prod_reg[i*3+j] <= fx_mul(view_reg[i*4+j], vtx[j]);
                end
            end

            b_xf_reg   <= a_xf_reg;
            b_idx_reg  <= a_idx_reg;
            b_coef_reg <= a_coef_reg;
            for (int i = 0; i < 4; i++) begin
                b_cam_reg[i] <= sat32(ACC_W'(a_tr_reg[i]) + ACC_W'(a_prod_reg[i*3])
                                      + ACC_W'(a_prod_reg[i*3+1])
                                      + ACC_W'(a_prod_reg[i*3+2]));
            end

            c_cz_reg <= b_cam_reg[2];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 4; j++) begin
                    c_prod_reg[i*4+j] <= fx_mul(proj_reg[i*4+j], b_cam_reg[j]);
                end
            end

            d_cz_reg <= c_cz_reg;
            for (int i = 0; i < 3; i++) begin
                d_prj_reg[i] <= ACC_W'(c_prod_reg[i*4]) + ACC_W'(c_prod_reg[i*4+1])
                                + ACC_W'(c_prod_reg[i*4+2]) + ACC_W'(c_prod_reg[i*4+3]);
            end
        end
    end

    // divider set-up: magnitudes, signs and quotient overflow
    always_comb begin
        logic [ACC_W-1:0]    mag;
        logic [SCALED_W-1:0] scaled;
        logic [HI_W-1:0]     hi;
        dv_next[0]       = '0;
        dv_next[0].den   = d_cz_reg[31] ? 32'(-d_cz_reg) : 32'(d_cz_reg);
        dv_next[0].fault = (d_cz_reg == '0);
        for (int l = 0; l < 3; l++) begin
            mag    = d_prj_reg[l][ACC_W-1] ? ACC_W'(-d_prj_reg[l]) : ACC_W'(d_prj_reg[l]);
            scaled = SCALED_W'(mag) << FRAC_BITS;
            hi     = scaled[SCALED_W-1:32];
            dv_next[0].num_neg[l] = d_prj_reg[l][ACC_W-1];
            // divisor is -cz: negative when cz is positive
            dv_next[0].neg[l] = d_prj_reg[l][ACC_W-1] !=
                                (!d_cz_reg[31] && d_cz_reg != '0);
            dv_next[0].ovf[l] = (hi >= HI_W'(dv_next[0].den));
            dv_next[0].lane[l].rem = hi[31:0];
            dv_next[0].lane[l].low = scaled[31:0];
            dv_next[0].lane[l].quo = '0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_comb begin
            logic [32:0] trial;
            logic        ge;
            dv_next[k+1] = dv_reg[k];
            for (int l = 0; l < 3; l++) begin
                trial = {dv_reg[k].lane[l].rem, dv_reg[k].lane[l].low[31]};
                ge    = (trial >= {1'b0, dv_reg[k].den});
                dv_next[k+1].lane[l].rem = ge ? 32'(trial - {1'b0, dv_reg[k].den})
                                              : trial[31:0];
                dv_next[k+1].lane[l].low = {dv_reg[k].lane[l].low[30:0], 1'b0};
                dv_next[k+1].lane[l].quo = {dv_reg[k].lane[l].quo[30:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // sign and saturate the quotient
    always_comb begin
        logic [31:0] q;
        for (int l = 0; l < 3; l++) begin
            q = dv_reg[DIV_STEPS].lane[l].quo;
            if (dv_reg[DIV_STEPS].fault) begin
                ndc_next[l] = dv_reg[DIV_STEPS].num_neg[l] ? S32_MIN : S32_MAX;
            end else if (dv_reg[DIV_STEPS].ovf[l]) begin
                ndc_next[l] = dv_reg[DIV_STEPS].neg[l] ? S32_MIN : S32_MAX;
            end else if (dv_reg[DIV_STEPS].neg[l]) begin
                ndc_next[l] = (q > 32'h8000_0000) ? S32_MIN : $signed(-q);
            end else begin
                ndc_next[l] = (q > 32'h7FFF_FFFF) ? S32_MAX : $signed(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                ndc_reg[l] <= ndc_next[l];
            end
            fault_reg <= dv_reg[DIV_STEPS].fault;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_ndc_x        = ndc_reg[0];
    assign m_ndc_y        = ndc_reg[1];
    assign m_ndc_z        = ndc_reg[2];
    assign m_divide_fault = fault_reg;

    // a faulted result is always saturated
    a_fault_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_fault) |->
            ((m_ndc_x == S32_MAX || m_ndc_x == S32_MIN) &&
             (m_ndc_y == S32_MAX || m_ndc_y == S32_MIN) &&
             (m_ndc_z == S32_MAX || m_ndc_z == S32_MIN)))
        else $error("fault result not saturated");

    // the output, stage A and stage D are empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_valid && !a_vld_reg && !d_vld_reg))
        else $error("pipeline not empty after reset");

    // a stalled pipeline holds its last divider stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(dv_vld_reg[DIV_STEPS]))
        else $error("divider advanced during stall");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Testbench for vertex_to_ndc_transform.
    // Predict each transform result from a local copy of both matrices, updated
    // on every accepted load, and queue it. Compare every result transaction
    // with the oldest queued prediction, field by field.

    import v2ndc_pkg::*;

    // Command 3 has no meaning and must be dropped by the block
    localparam cmd_t CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    // Extra wait at the end, longer than the pipeline latency
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               fault;
    } ndc_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cmd_t               s_cmd = CMD_UNUSED;
    logic [3:0]         s_coef_index = '0;
    logic signed [31:0] s_coef_value = '0;
    logic signed [31:0] s_vertex_x = '0;
    logic signed [31:0] s_vertex_y = '0;
    logic signed [31:0] s_vertex_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_ndc_x;
    logic signed [31:0] m_ndc_y;
    logic signed [31:0] m_ndc_z;
    logic               m_divide_fault;

    // Local copies of the camera-inverse and projection matrices
    logic signed [31:0] view_coef [16];
    logic signed [31:0] proj_coef [16];
    ndc_result_t        pending_ndc [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    // Set for a stretch with no idling on either side
    bit  calm = 1'b0;
    // Request a long receiver hold-off; the receiver counts it down itself
    int  hold_request = 0;

    vertex_to_ndc_transform i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_coef_index   (s_coef_index),
        .s_coef_value   (s_coef_value),
        .s_vertex_x     (s_vertex_x),
        .s_vertex_y     (s_vertex_y),
        .s_vertex_z     (s_vertex_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ndc_x        (m_ndc_x),
        .m_ndc_y        (m_ndc_y),
        .m_ndc_z        (m_ndc_z),
        .m_divide_fault (m_divide_fault)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Fixed-point arithmetic of the transform
    // ---------------------------------------------------------------------

    // Full 64-bit product, arithmetic shift gives rounding toward minus infinity
    function automatic longint fix_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7FFF_FFFF) begin
            return 64'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // (num << FRAC_BITS) / den, truncated toward zero and saturated
    function automatic logic [31:0] fix_div(input longint num, input longint den);
        bit              neg;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned r;
        longint unsigned mag;
        longint          res;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = un / ud;
        r   = un % ud;
        // A huge quotient only needs to land beyond the saturation point
        if (q >= 64'h1_0000_0000) begin
            mag = 64'h100_0000_0000;
        end else begin
            mag = (q << FRAC_BITS) + ((r << FRAC_BITS) / ud);
        end
        res = neg ? -longint'(mag) : longint'(mag);
        res = clamp32(res);
        return res[31:0];
    endfunction

    function automatic ndc_result_t project_vertex(input logic signed [31:0] vx,
                                                   input logic signed [31:0] vy,
                                                   input logic signed [31:0] vz);
        longint      vtx [3];
        longint      cam [4];
        longint      prj [3];
        longint      acc;
        ndc_result_t res;
        vtx[0] = vx;
        vtx[1] = vy;
        vtx[2] = vz;
        // Camera space: the w = 1 term adds the translation column unchanged
        for (int i = 0; i < 4; i++) begin
            acc = view_coef[i*4 + 3];
            for (int j = 0; j < 3; j++) begin
                acc += fix_mul(view_coef[i*4 + j], vtx[j]);
            end
            cam[i] = clamp32(acc);
        end
        // Projected values are kept at full width
        for (int i = 0; i < 3; i++) begin
            prj[i] = fix_mul(proj_coef[i*4 + 3], cam[3]);
            for (int j = 0; j < 3; j++) begin
                prj[i] += fix_mul(proj_coef[i*4 + j], cam[j]);
            end
        end
        res.fault = (cam[2] == 0);
        if (res.fault) begin
            res.x = (prj[0] >= 0) ? S32_MAX : S32_MIN;
            res.y = (prj[1] >= 0) ? S32_MAX : S32_MIN;
            res.z = (prj[2] >= 0) ? S32_MAX : S32_MIN;
        end else begin
            res.x = fix_div(prj[0], -cam[2]);
            res.y = fix_div(prj[1], -cam[2]);
            res.z = fix_div(prj[2], -cam[2]);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: drive at the falling edge, detect acceptance at the rising edge
    // ---------------------------------------------------------------------
    task automatic send_item(input cmd_t cmd, input logic [3:0] idx,
                             input logic signed [31:0] coef,
                             input logic signed [31:0] vx,
                             input logic signed [31:0] vy,
                             input logic signed [31:0] vz);
        @(negedge aclk);
        // Random gaps before the transaction
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_coef_index <= idx;
        s_coef_value <= coef;
        s_vertex_x   <= vx;
        s_vertex_y   <= vy;
        s_vertex_z   <= vz;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        // Accepted: advance the local state in acceptance order
        case (cmd)
            CMD_LOAD_VIEW: view_coef[idx] = coef;
            CMD_LOAD_PROJ: proj_coef[idx] = coef;
            CMD_XFORM:     pending_ndc = {pending_ndc, project_vertex(vx, vy, vz)};
            default: ;
        endcase
    endtask

    // Lower valid after the last transaction of a burst
    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic load_coef(input cmd_t cmd, input logic [3:0] idx,
                             input logic signed [31:0] coef);
        send_item(cmd, idx, coef, $urandom, $urandom, $urandom);
    endtask

    task automatic transform(input logic signed [31:0] vx, input logic signed [31:0] vy,
                             input logic signed [31:0] vz);
        send_item(CMD_XFORM, 4'($urandom), $urandom, vx, vy, vz);
    endtask

    task automatic wait_drain();
        end_burst();
        while (pending_ndc.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Q16.16 value: mostly modest magnitudes, sometimes the full range
    function automatic logic signed [31:0] rand_fix();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(8)) <<< 16;
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: random idling plus a requested long hold-off
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        static int hold_left = 0;
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        ndc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ndc.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result x=%h y=%h z=%h fault=%b",
                             m_ndc_x, m_ndc_y, m_ndc_z, m_divide_fault);
                end
            end else begin
                want = pending_ndc.pop_front();
                if (m_ndc_x !== want.x || m_ndc_y !== want.y || m_ndc_z !== want.z
                        || m_divide_fault !== want.fault) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected x=%h y=%h z=%h fault=%b",
                                 want.x, want.y, want.z, want.fault);
                        $display("          actual   x=%h y=%h z=%h fault=%b",
                                 m_ndc_x, m_ndc_y, m_ndc_z, m_divide_fault);
                    end
                end
            end
        end
    end

    // Hard stop should the block hang
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL vertex_to_ndc_transform");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Write every coefficient of both matrices: camera at z = +5 looking
    // down -z, and a simple perspective projection
    task automatic test_matrix_load();
        logic signed [31:0] view_init [16];
        logic signed [31:0] proj_init [16];
        view_init = '{32'sh1_0000, 0, 0, 0,
                      0, 32'sh1_0000, 0, 0,
                      0, 0, 32'sh1_0000, -32'sh5_0000,
                      0, 0, 0, 32'sh1_0000};
        proj_init = '{32'sh1_8000, 0, 0, 0,
                      0, 32'sh1_8000, 0, 0,
                      0, 0, -32'sh1_0400, -32'sh0_3333,
                      0, 0, -32'sh1_0000, 0};
        for (int i = 0; i < 16; i++) begin
            load_coef(CMD_LOAD_VIEW, 4'(i), view_init[i]);
            load_coef(CMD_LOAD_PROJ, 4'(i), proj_init[i]);
        end
    endtask

    // Field extremes, two dropped commands and a load carrying vertex junk
    task automatic test_field_extremes();
        transform(0, 0, 0);
        transform(32'sh7FFF_FFFF, 0, 0);
        transform(32'sh8000_0000, 0, 0);
        transform(0, 32'sh7FFF_FFFF, 0);
        transform(0, 32'sh8000_0000, 0);
        transform(0, 0, 32'sh7FFF_FFFF);
        transform(0, 0, 32'sh8000_0000);
        transform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        transform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        transform(32'sh1_0000, -32'sh2_0000, 32'sh3_8000);
        send_item(CMD_UNUSED, 4'hF, 32'sh7FFF_FFFF, 1, 2, 3);
        send_item(CMD_UNUSED, 4'h0, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
        transform(32'sh2_0000, 32'sh2_0000, 0);
        send_item(CMD_LOAD_VIEW, 4'd0, 32'sh1_0000, 32'sh7FFF_FFFF, -1, 32'sh8000_0000);
        transform(32'sh2_0000, 32'sh2_0000, 0);
    endtask

    // Flatten camera z to zero so every vertex hits the divide fault
    task automatic test_zero_depth();
        logic signed [31:0] keep [4];
        for (int i = 0; i < 4; i++) begin
            keep[i] = view_coef[8 + i];
            load_coef(CMD_LOAD_VIEW, 4'(8 + i), 0);
        end
        transform(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        transform(-32'sh1_0000, -32'sh1_0000, 32'sh7FFF_FFFF);
        transform(0, 0, 0);
        for (int i = 0; i < 4; i++) begin
            load_coef(CMD_LOAD_VIEW, 4'(8 + i), keep[i]);
        end
    endtask

    // Extreme coefficients drive both saturation stages
    task automatic test_saturation();
        load_coef(CMD_LOAD_PROJ, 4'd0, 32'sh7FFF_FFFF);
        load_coef(CMD_LOAD_PROJ, 4'd5, 32'sh8000_0000);
        load_coef(CMD_LOAD_VIEW, 4'd10, 32'sh0000_0001);
        transform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000);
        transform(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        load_coef(CMD_LOAD_VIEW, 4'd11, 32'sh7FFF_FFFF);
        load_coef(CMD_LOAD_VIEW, 4'd0, 32'sh7FFF_FFFF);
        transform(32'sh7FFF_FFFF, 0, 0);
        transform(32'sh8000_0000, 0, 32'sh8000_0000);
    endtask

    // Hold the receiver off while the sender keeps offering, so that the
    // pipeline fills and stalls its input
    task automatic test_back_pressure();
        calm = 1'b1;
        @(negedge aclk);
        hold_request = 300;
        for (int i = 0; i < 120; i++) begin
            transform(rand_fix(), rand_fix(), rand_fix());
        end
        wait_drain();
        calm = 1'b0;
    endtask

    // Random traffic: mostly transforms, some reloads, a little noise
    task automatic test_random_stream(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                load_coef(CMD_LOAD_VIEW, 4'($urandom), rand_fix());
            end else if (pick < 16) begin
                load_coef(CMD_LOAD_PROJ, 4'($urandom), rand_fix());
            end else if (pick < 19) begin
                send_item(CMD_UNUSED, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
            end else begin
                transform(rand_fix(), rand_fix(), rand_fix());
            end
            // Pause once until every expected result has come
            if (n == count / 2) begin
                wait_drain();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            view_coef[i] = '0;
            proj_coef[i] = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_matrix_load();
        test_field_extremes();
        test_zero_depth();
        test_saturation();
        test_matrix_load();
        test_back_pressure();
        test_random_stream(1000);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_ndc.size() == 0) begin
            $display("PASS vertex_to_ndc_transform");
        end else begin
            $display("FAIL vertex_to_ndc_transform");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/v2ndc_pkg.sv
rtl/core/vertex_to_ndc_transform.sv
verif/tb_top.sv
